// ===== hdl/mhb_pkg.sv =====
// Package with the request, result and job types of the MAC header builder.
`timescale 1ns / 1ps

package mhb_pkg;

  localparam logic [2:0] FC_TYPE_DATA = 3'd1;
  localparam logic [1:0] FC_VERSION_2003 = 2'd0;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd2;
  localparam logic [1:0] MODE_LONG = 2'd3;

  localparam logic [4:0] FIXED_BYTES = 5'd3;
  localparam logic [4:0] PAN_BYTES = 5'd2;
  localparam logic [4:0] SHORT_BYTES = 5'd2;
  localparam logic [4:0] LONG_BYTES = 5'd8;
  localparam logic [4:0] MAX_LEN = 5'd23;

  typedef struct packed {
    logic        has_src_pan;
    logic [15:0] src_pan_id;
    logic        has_dst_pan;
    logic [15:0] dst_pan_id;
    logic [1:0]  src_mode;
    logic [63:0] src_addr;
    logic [1:0]  dst_mode;
    logic [63:0] dst_addr;
    logic        ack_request;
    logic [7:0]  space_available;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       too_small;
    logic [4:0] total_length;
  } rsp_t;

  typedef struct packed {
    logic        too_small;
    logic [4:0]  total_length;
    logic [15:0] fc;
    logic [15:0] dst_pan;
    logic [1:0]  dst_mode;
    logic [63:0] dst_addr;
    logic [15:0] src_pan;
    logic [1:0]  src_mode;
    logic [63:0] src_addr;
    logic [4:0]  daddr_off;
    logic [4:0]  span_off;
    logic [4:0]  saddr_off;
  } job_t;

  function automatic logic [4:0] mode_bytes(logic [1:0] mode);
    logic [4:0] n;
    case (mode)
      MODE_SHORT: n = SHORT_BYTES;
      MODE_LONG:  n = LONG_BYTES;
      default:    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] addr_byte(logic [63:0] addr, logic [2:0] idx);
    logic [63:0] sh;
    sh = addr >> {idx, 3'b000};
    return sh[7:0];
  endfunction

endpackage

// ===== hdl/mhb_queue.sv =====
// Short job queue between the request front end and the byte sequencer.
`timescale 1ns / 1ps

module mhb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mhb_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mhb_pkg::job_t head_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mhb_pkg::job_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Job pushed into a full queue.");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("Job popped from an empty queue.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + CntW'(1))
    else $error("Queue fill count did not follow a push.");

endmodule

// ===== hdl/mhb_front.sv =====
// Request front end: classifies a request and builds the job for the sequencer.
`timescale 1ns / 1ps

module mhb_front (
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mhb_pkg::req_t in_req_i,
  input  logic          full_i,
  output logic          push_o,
  output mhb_pkg::job_t job_o
);

  logic       comp;
  logic       span_en;
  logic [4:0] daddr_off;
  logic [4:0] span_off;
  logic [4:0] saddr_off;
  logic [4:0] len;
  logic       too_small;

  assign in_ready_o = !full_i;
  assign push_o = in_valid_i && !full_i;

  always_comb begin
    comp = in_req_i.has_src_pan && in_req_i.has_dst_pan &&
           (in_req_i.src_mode != mhb_pkg::MODE_NONE) &&
           (in_req_i.dst_mode != mhb_pkg::MODE_NONE) &&
           (in_req_i.src_pan_id == in_req_i.dst_pan_id);
    span_en = in_req_i.has_src_pan && !comp;
    daddr_off = mhb_pkg::FIXED_BYTES +
                (in_req_i.has_dst_pan ? mhb_pkg::PAN_BYTES : 5'd0);
    span_off = daddr_off + mhb_pkg::mode_bytes(in_req_i.dst_mode);
    saddr_off = span_off + (span_en ? mhb_pkg::PAN_BYTES : 5'd0);
    len = saddr_off + mhb_pkg::mode_bytes(in_req_i.src_mode);
    too_small = ({3'b000, len} > in_req_i.space_available);

    job_o.too_small = too_small;
    job_o.total_length = too_small ? 5'd0 : len;
    job_o.fc = {in_req_i.src_mode, mhb_pkg::FC_VERSION_2003, in_req_i.dst_mode,
                3'b000, comp, in_req_i.ack_request, 2'b00, mhb_pkg::FC_TYPE_DATA};
    job_o.dst_pan = in_req_i.dst_pan_id;
    job_o.dst_mode = in_req_i.dst_mode;
    job_o.dst_addr = in_req_i.dst_addr;
    job_o.src_pan = in_req_i.src_pan_id;
    job_o.src_mode = in_req_i.src_mode;
    job_o.src_addr = in_req_i.src_addr;
    job_o.daddr_off = daddr_off;
    job_o.span_off = span_off;
    job_o.saddr_off = saddr_off;
  end

endmodule

// ===== hdl/mhb_back.sv =====
// Byte sequencer: walks the head job byte by byte into the output register.
`timescale 1ns / 1ps

module mhb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mhb_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mhb_pkg::rsp_t out_rsp_o
);

  logic [4:0]    pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  mhb_pkg::rsp_t out_rsp_q;
  logic          load;
  logic          last;
  logic [7:0]    byte_sel;
  logic [4:0]    rel_daddr;
  logic [4:0]    rel_span;
  logic [4:0]    rel_saddr;

  assign load = job_valid_i && (!out_valid_q || out_ready_i);
  assign last = job_i.too_small || (pos_q == job_i.total_length - 5'd1);
  assign job_pop_o = load && last;

  always_comb begin
    rel_daddr = pos_q - job_i.daddr_off;
    rel_span = pos_q - job_i.span_off;
    rel_saddr = pos_q - job_i.saddr_off;
    if (pos_q == 5'd0) begin
      byte_sel = job_i.fc[7:0];
    end else if (pos_q == 5'd1) begin
      byte_sel = job_i.fc[15:8];
    end else if (pos_q == 5'd2) begin
      byte_sel = 8'h00;
    end else if (pos_q < job_i.daddr_off) begin
      byte_sel = pos_q[0] ? job_i.dst_pan[7:0] : job_i.dst_pan[15:8];
    end else if (pos_q < job_i.span_off) begin
      if (job_i.dst_mode == mhb_pkg::MODE_LONG) begin
        byte_sel = mhb_pkg::addr_byte(job_i.dst_addr, ~rel_daddr[2:0]);
      end else begin
        byte_sel = mhb_pkg::addr_byte(job_i.dst_addr, {2'b00, rel_daddr[0]});
      end
    end else if (pos_q < job_i.saddr_off) begin
      byte_sel = rel_span[0] ? job_i.src_pan[15:8] : job_i.src_pan[7:0];
    end else if (job_i.src_mode == mhb_pkg::MODE_LONG) begin
      byte_sel = mhb_pkg::addr_byte(job_i.src_addr, ~rel_saddr[2:0]);
    end else begin
      byte_sel = mhb_pkg::addr_byte(job_i.src_addr, {2'b00, rel_saddr[0]});
    end
  end

  always_comb begin
    pos_d = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      pos_d = last ? 5'd0 : pos_q + 5'd1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rsp_q.out_byte <= job_i.too_small ? 8'h00 : byte_sel;
      out_rsp_q.last_byte <= last;
      out_rsp_q.too_small <= job_i.too_small;
      out_rsp_q.total_length <= job_i.total_length;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o = out_rsp_q;

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> pos_q == 5'd0)
    else $error("Byte position did not restart after the last byte of a request.");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < mhb_pkg::MAX_LEN)
    else $error("Byte position ran past the longest header.");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && job_i.too_small |=> out_rsp_q.last_byte && out_rsp_q.total_length == 5'd0)
    else $error("Error result was not a single final result.");

endmodule

// ===== hdl/mac_data_frame_header_builder_unit.sv =====
// Top level of the IEEE 802.15.4 data-frame MAC header builder.
`timescale 1ns / 1ps

// Each request on the input channel (in_valid_i, in_ready_o, in_req_i) describes one
// data frame: optional PAN identifiers, address modes and addresses, the ack-request
// flag and the room available. The output channel (out_valid_o, out_ready_i,
// out_rsp_o) returns the MAC header one byte per result in transmission order, with
// last_byte set on the final byte and total_length on every byte.
// If the header does not fit, the request yields a single result with too_small set.
// A request is classified in the cycle it is accepted and queued; its job is
// registered in the queue, then its first byte in the output register. The
// sequencer delivers one byte per cycle while the receiver is ready; a request
// yields 3 to 23 bytes (one on error); a queued next request follows with no gap.
// The job queue holds QUEUE_DEPTH requests; in_ready_o drops only while it is full.
// When the receiver stalls, the output register holds its byte and the sequencer
// waits; requests keep being accepted until the queue fills.
// Reset empties the queue and clears the output valid.
module mac_data_frame_header_builder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mhb_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mhb_pkg::rsp_t out_rsp_o
);

  mhb_pkg::job_t push_job;
  mhb_pkg::job_t head_job;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;

  mhb_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  mhb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_job)
  );

  mhb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
